/* hw/rtl/pfi_pkg.sv */
// Shared types, constants and lookup functions for the PNG stream frame indexer.
package pfi_pkg;

  // Result kind, carried on the master-side tuser.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,  // frame complete
    ST_BAD_SIG = 2'd1,  // signature mismatch, parser halted
    ST_TRUNC   = 2'd2   // stream ended inside a frame
  } status_t;

  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned CRC_BYTES  = 4;

  typedef struct packed {
    logic [FIELD_BITS-1:0] frame_size;
    logic [FIELD_BITS-1:0] frame_offset;
    status_t               status;
  } pfi_result_t;

  // PNG signature 89 50 4E 47 0D 0A 1A 0A
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Chunk type "IEND"
  function automatic logic [7:0] iend_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h49;
      2'd1: b = 8'h45;
      2'd2: b = 8'h4E;
      2'd3: b = 8'h44;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/pfi_parser.sv */
// Per-byte PNG chunk parser: state registers and single-pass next-state logic.
module pfi_parser
  import pfi_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,        // process the byte below this cycle
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        res_valid,
  output pfi_result_t res
);

  typedef enum logic [1:0] {
    PH_SIG  = 2'd0,
    PH_HDR  = 2'd1,
    PH_SKIP = 2'd2
  } phase_t;

  localparam int unsigned SKIP_BITS = FIELD_BITS + 1;

  phase_t                 phase, phase_next;
  logic [2:0]             byte_in_phase, byte_in_phase_next;
  logic [FIELD_BITS-1:0]  chunk_length, chunk_length_next;
  logic [SKIP_BITS-1:0]   skip_remaining, skip_remaining_next;
  logic                   type_is_iend, type_is_iend_next;
  logic [OFFSET_BITS-1:0] stream_position, stream_position_next;
  logic [OFFSET_BITS-1:0] frame_start, frame_start_next;
  logic                   halted, halted_next;

  logic                   bad;
  logic                   iend_match;
  logic [OFFSET_BITS-1:0] size_full;

  assign size_full = stream_position + OFFSET_BITS'(1) - frame_start_next;

  always_comb begin
    phase_next           = phase;
    byte_in_phase_next   = byte_in_phase;
    chunk_length_next    = chunk_length;
    skip_remaining_next  = skip_remaining;
    type_is_iend_next    = type_is_iend;
    stream_position_next = stream_position;
    frame_start_next     = frame_start;
    halted_next          = halted;
    bad                  = 1'b0;
    iend_match           = (data_byte == iend_byte(byte_in_phase[1:0]));
    res_valid            = 1'b0;
    res.status           = ST_DONE;

    if (!halted) begin
      stream_position_next = stream_position + OFFSET_BITS'(1);
      unique case (phase)
        PH_SIG: begin
          if (byte_in_phase == 3'd0) begin
            frame_start_next = stream_position;
          end
          if (data_byte != sig_byte(byte_in_phase)) begin
            bad         = 1'b1;
            halted_next = 1'b1;
            res_valid   = 1'b1;
            res.status  = ST_BAD_SIG;
          end else if (byte_in_phase == 3'd7) begin
            phase_next         = PH_HDR;
            byte_in_phase_next = 3'd0;
          end else begin
            byte_in_phase_next = byte_in_phase + 3'd1;
          end
        end
        PH_HDR: begin
          if (!byte_in_phase[2]) begin
            chunk_length_next = {chunk_length[FIELD_BITS-9:0], data_byte};
          end else if (byte_in_phase[1:0] == 2'd0) begin
            type_is_iend_next = iend_match;
          end else begin
            type_is_iend_next = type_is_iend && iend_match;
          end
          if (byte_in_phase == 3'd7) begin
            skip_remaining_next = {1'b0, chunk_length} + SKIP_BITS'(CRC_BYTES);
            phase_next          = PH_SKIP;
            byte_in_phase_next  = 3'd0;
          end else begin
            byte_in_phase_next = byte_in_phase + 3'd1;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_remaining - SKIP_BITS'(1);
          if (skip_remaining == SKIP_BITS'(1)) begin
            if (type_is_iend) begin
              res_valid  = 1'b1;
              res.status = ST_DONE;
              phase_next = PH_SIG;
            end else begin
              phase_next = PH_HDR;
            end
            byte_in_phase_next = 3'd0;
            chunk_length_next  = '0;
          end
        end
        default: begin
          phase_next         = PH_SIG;
          byte_in_phase_next = 3'd0;
        end
      endcase

      // end of stream: report a partial frame, then rearm for a new stream
      if (end_of_stream && !bad) begin
        if (!res_valid && !(phase_next == PH_SIG && byte_in_phase_next == 3'd0)) begin
          res_valid  = 1'b1;
          res.status = ST_TRUNC;
        end
        phase_next           = PH_SIG;
        byte_in_phase_next   = 3'd0;
        chunk_length_next    = '0;
        skip_remaining_next  = '0;
        type_is_iend_next    = 1'b0;
        stream_position_next = '0;
      end
    end

    res.frame_offset = FIELD_BITS'(frame_start_next);
    res.frame_size   = FIELD_BITS'(size_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIG;
      byte_in_phase   <= 3'd0;
      chunk_length    <= '0;
      skip_remaining  <= '0;
      type_is_iend    <= 1'b0;
      stream_position <= '0;
      frame_start     <= '0;
      halted          <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      byte_in_phase   <= byte_in_phase_next;
      chunk_length    <= chunk_length_next;
      skip_remaining  <= skip_remaining_next;
      type_is_iend    <= type_is_iend_next;
      stream_position <= stream_position_next;
      frame_start     <= frame_start_next;
      halted          <= halted_next;
    end
  end

endmodule

/* hw/rtl/pfi_out_reg.sv */
// Result register with valid/ready handshake toward the master side.
module pfi_out_reg
  import pfi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  pfi_result_t load_data,
  output logic        free,       // can take a new result this cycle
  output logic        valid,
  input  logic        ready,
  output pfi_result_t data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

/* hw/rtl/png_stream_frame_indexer.sv */
// Top level of the PNG stream frame indexer: input register, parser, result register.
// Splits a byte stream of back-to-back PNG files into frames, one byte per
// transaction on the slave side. Each frame must open with the 8-byte PNG
// signature; chunk headers (4-byte big-endian length, 4-byte type) are parsed
// and the chunk data plus CRC are skipped unchecked. The frame closes on the
// last CRC byte of the IEND chunk, and one transaction on the master side
// carries its start offset and size. A signature mismatch reports bad
// signature and the block then swallows all input without results until
// reset. tlast on a byte that does not close a frame, once a frame has begun,
// reports a truncated frame; after any tlast the byte offset restarts at 0.
// Offsets count modulo 2^OFFSET_BITS and are presented as 32 bits.
// Throughput is one byte per clock sustained while the master side takes
// results without stalling. An accepted byte passes through the input
// register, then the parser's single-pass update writes the result register.
// The input stage keeps taking bytes while a result waits, until both the
// input register and the result register are full.
module png_stream_frame_indexer
  import pfi_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] frame_offset, [63:32] frame_size
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic        out_free;
  logic        advance;      // parser consumes the buffered byte
  logic        res_valid;
  pfi_result_t res;
  pfi_result_t out_data;

  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  pfi_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_byte    (in_byte),
    .end_of_stream(in_last),
    .res_valid    (res_valid),
    .res          (res)
  );

  pfi_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .load_data(res),
    .free     (out_free),
    .valid    (m_axis_tvalid),
    .ready    (m_axis_tready),
    .data     (out_data)
  );

  assign m_axis_tdata = {out_data.frame_size, out_data.frame_offset};
  assign m_axis_tuser = out_data.status;

endmodule

/* hw/rtl/pfi_checker.sv */
// Port-level assertions for the PNG stream frame indexer, bound to the top level.
module pfi_checker
  import pfi_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic seen_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_bad <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser == ST_BAD_SIG) begin
      seen_bad <= 1'b1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // once a bad signature is delivered, the parser stays silent
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    seen_bad |-> !m_axis_tvalid)
    else $error("result after bad signature");

  // a bad signature is found within the 8 signature bytes
  a_bad_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_BAD_SIG |->
      m_axis_tdata[63:32] != 32'd0 && m_axis_tdata[63:32] <= 32'd8)
    else $error("bad signature size out of range");

  // with the result register empty the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == ST_DONE || m_axis_tuser == ST_BAD_SIG ||
                      m_axis_tuser == ST_TRUNC)
    else $error("undefined status code");

endmodule

bind png_stream_frame_indexer pfi_checker u_pfi_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for png_stream_frame_indexer: byte streams of PNG frames in, frame records checked out.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfi_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;   // cycles without any transaction
  localparam int unsigned RANDOM_BYTES = 500;
  localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] IEND_TAG = 32'h4945_4E44;   // "IEND"
  localparam logic [31:0] IDAT_TAG = 32'h4944_4154;   // "IDAT"

  typedef enum logic [1:0] {
    PH_SIGNATURE,
    PH_HEADER,
    PH_SKIP
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;    // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;           // [31:0] frame_offset, [63:32] frame_size
  logic [1:0]  m_axis_tuser;           // [1:0] status

  png_stream_frame_indexer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame parser shadow: mirrors the block's state, one accepted byte at a time
  // ---------------------------------------------------------------------------
  parse_phase_t ph = PH_SIGNATURE;
  logic [2:0]   ph_idx = '0;       // byte within signature or chunk header
  logic [31:0]  len_acc = '0;
  logic [32:0]  skip_left = '0;    // data + CRC bytes still to pass over
  logic         tag_is_iend = 1'b0;
  logic [31:0]  next_pos = '0;     // stream offset of the next byte
  logic [31:0]  frame_base = '0;
  logic         parser_halted = 1'b0;

  pfi_result_t  frames_due[$];     // frame records waiting on the master side
  int unsigned  bytes_fed = 0;     // bytes the parser actually consumed
  int unsigned  mismatches = 0;
  logic         steady = 1'b0;     // suppresses idling on both sides
  logic [7:0]   frame_bytes[$];    // frame under construction

  function automatic void note_result(input status_t st, input logic [31:0] here);
    pfi_result_t r;
    r.status       = st;
    r.frame_offset = frame_base;
    r.frame_size   = here + 32'd1 - frame_base;
    frames_due.push_back(r);
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic last);
    logic [31:0] here;
    logic        closed;
    logic        hit;
    if (parser_halted)
      return;
    bytes_fed++;
    here     = next_pos;
    next_pos = here + 32'd1;
    closed   = 1'b0;
    case (ph)
      PH_SIGNATURE: begin
        if (ph_idx == 3'd0)
          frame_base = here;
        if (b != PNG_MAGIC[63 - 8*ph_idx -: 8]) begin
          // bad magic: report once, then swallow everything until reset
          note_result(ST_BAD_SIG, here);
          parser_halted = 1'b1;
          return;
        end
        if (ph_idx == 3'd7) begin
          ph     = PH_HEADER;
          ph_idx = '0;
        end else begin
          ph_idx = ph_idx + 3'd1;
        end
      end
      PH_HEADER: begin
        if (ph_idx < 3'd4) begin
          len_acc = {len_acc[23:0], b};
        end else begin
          hit = (b == IEND_TAG[31 - 8*(ph_idx - 3'd4) -: 8]);
          tag_is_iend = (ph_idx == 3'd4) ? hit : (tag_is_iend && hit);
        end
        if (ph_idx == 3'd7) begin
          skip_left = {1'b0, len_acc} + 33'd4;
          ph        = PH_SKIP;
          ph_idx    = '0;
        end else begin
          ph_idx = ph_idx + 3'd1;
        end
      end
      default: begin
        skip_left = skip_left - 33'd1;
        if (skip_left == '0) begin
          if (tag_is_iend) begin
            note_result(ST_DONE, here);
            closed = 1'b1;
            ph     = PH_SIGNATURE;
          end else begin
            ph = PH_HEADER;
          end
          ph_idx  = '0;
          len_acc = '0;
        end
      end
    endcase
    if (last) begin
      // tlast inside an open frame reports truncation; offsets restart either way
      if (!closed && !(ph == PH_SIGNATURE && ph_idx == 3'd0))
        note_result(ST_TRUNC, here);
      ph          = PH_SIGNATURE;
      ph_idx      = '0;
      len_acc     = '0;
      skip_left   = '0;
      tag_is_iend = 1'b0;
      next_pos    = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure, in-order compare against the shadow
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40)
      $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 19);
  end

  pfi_result_t head;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d offset=%0d size=%0d",
                                  m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]));
      end else begin
        head = frames_due.pop_front();
        if (m_axis_tuser !== head.status)
          report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, head.status));
        if (m_axis_tdata[31:0] !== head.frame_offset)
          report_mismatch($sformatf("frame_offset got %0d want %0d",
                                    m_axis_tdata[31:0], head.frame_offset));
        if (m_axis_tdata[63:32] !== head.frame_size)
          report_mismatch($sformatf("frame_size got %0d want %0d",
                                    m_axis_tdata[63:32], head.frame_size));
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------
  // One byte transaction; tvalid stays high into the next byte unless an idle
  // cycle is drawn, so back-to-back bytes never lower and raise it in one step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    track_byte(b, last);
  endtask

  // Sends the first count bytes of frame_bytes, tlast on the final one if asked
  task automatic send_bytes(input int count, input logic end_stream);
    for (int i = 0; i < count; i++)
      send_byte(frame_bytes[i], end_stream && (i == count - 1));
  endtask

  task automatic add_chunk(input logic [31:0] tag, input int unsigned len);
    logic [31:0] l32;
    l32 = len;
    for (int i = 3; i >= 0; i--)
      frame_bytes.push_back(l32[8*i +: 8]);
    for (int i = 3; i >= 0; i--)
      frame_bytes.push_back(tag[8*i +: 8]);
    repeat (len + 4)                     // data then CRC, both unchecked
      frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Signature, a few chunks with random, IDAT or IEND-lookalike types, closing IEND
  task automatic build_frame(input int n_chunks);
    logic [31:0] tag;
    int unsigned pos;
    frame_bytes.delete();
    for (int i = 0; i < 8; i++)
      frame_bytes.push_back(PNG_MAGIC[63 - 8*i -: 8]);
    repeat (n_chunks) begin
      case ($urandom_range(0, 3))
        0: tag = $urandom;
        1, 2: begin
          // one byte off from IEND: exercises the match at every type position
          tag = IEND_TAG;
          pos = $urandom_range(0, 3);
          tag[8*pos +: 8] = tag[8*pos +: 8] ^ 8'($urandom_range(1, 255));
        end
        default: tag = IDAT_TAG;
      endcase
      add_chunk(tag, ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 6));
    end
    add_chunk(IEND_TAG, ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Frame with an IEND chunk only, closed by tlast on its last CRC byte: one record only
  task automatic test_minimal_frame_at_end();
    build_frame(0);
    send_bytes(frame_bytes.size(), 1'b1);
  endtask

  // tlast three bytes into the signature; next stream restarts at offset 0
  task automatic test_cut_in_signature();
    build_frame(0);
    send_bytes(3, 1'b1);
  endtask

  // Chunk length 0xFFFFFFFF: skip counter needs its 33rd bit; cut after
  // two data bytes that hit both byte extremes
  task automatic test_huge_chunk_cut();
    frame_bytes.delete();
    for (int i = 0; i < 8; i++)
      frame_bytes.push_back(PNG_MAGIC[63 - 8*i -: 8]);
    repeat (4) frame_bytes.push_back(8'hFF);
    for (int i = 3; i >= 0; i--)
      frame_bytes.push_back(IDAT_TAG[8*i +: 8]);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    send_bytes(frame_bytes.size(), 1'b1);
  endtask

  // Long stretch with no idling on either side
  task automatic test_back_to_back_frames();
    steady = 1'b1;
    repeat (6) begin
      build_frame($urandom_range(0, 2));
      send_bytes(frame_bytes.size(), 1'b0);
    end
    steady = 1'b0;
  endtask

  // Mostly whole frames in one long stream, some ending the stream, some cut
  // anywhere (signature, header, data or CRC)
  task automatic test_random_stream();
    int unsigned pick;
    bytes_fed = 0;
    while (bytes_fed < RANDOM_BYTES) begin
      build_frame($urandom_range(0, 2));
      pick = $urandom_range(99);
      if (pick < 70)
        send_bytes(frame_bytes.size(), 1'b0);
      else if (pick < 80)
        send_bytes(frame_bytes.size(), 1'b1);
      else
        send_bytes($urandom_range(1, frame_bytes.size() - 1), 1'b1);
    end
  endtask

  // Corrupt one signature byte; the block halts, so this runs last. What
  // follows, tlast and a good frame included, must be swallowed silently.
  task automatic test_bad_signature();
    int unsigned k;
    k = $urandom_range(0, 7);
    build_frame(0);
    frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
    send_bytes(k + 1, 1'b0);
    build_frame(1);
    send_bytes(frame_bytes.size(), 1'b1);
    send_bytes(frame_bytes.size(), 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_minimal_frame_at_end();
    test_cut_in_signature();
    test_huge_chunk_cut();
    test_back_to_back_frames();
    test_random_stream();
    test_bad_signature();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    // drain; the watchdog bounds this wait
    while (frames_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);   // catch any stray record behind the input and result registers

    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
